// ----- rtl/creu_pkg.sv -----
// Shared types and constants for the register/ALU execute unit.
`default_nettype none

package creu_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned KIND_W = 6;

  // Status bit positions: N7 V6 D3 I2 Z1 C0
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [DATA_W-1:0] STATUS_RESET       = 8'h04;
  // Bits 5 and 4 are never written and stay clear
  localparam logic [DATA_W-1:0] STATUS_UNUSED_MASK = 8'h30;

  typedef enum logic [KIND_W-1:0] {
    KIND_LDA   = 6'd0,
    KIND_LDX   = 6'd1,
    KIND_LDY   = 6'd2,
    KIND_STA   = 6'd3,
    KIND_STX   = 6'd4,
    KIND_STY   = 6'd5,
    KIND_TAX   = 6'd6,
    KIND_TAY   = 6'd7,
    KIND_TXA   = 6'd8,
    KIND_TYA   = 6'd9,
    KIND_TXS   = 6'd10,
    KIND_TSX   = 6'd11,
    KIND_ADC   = 6'd12,
    KIND_SBC   = 6'd13,
    KIND_AND   = 6'd14,
    KIND_ORA   = 6'd15,
    KIND_EOR   = 6'd16,
    KIND_INX   = 6'd17,
    KIND_INY   = 6'd18,
    KIND_DEX   = 6'd19,
    KIND_DEY   = 6'd20,
    KIND_INC   = 6'd21,
    KIND_DEC   = 6'd22,
    KIND_CMP   = 6'd23,
    KIND_CPX   = 6'd24,
    KIND_CPY   = 6'd25,
    KIND_BIT   = 6'd26,
    KIND_LSR_M = 6'd27,
    KIND_LSR_A = 6'd28,
    KIND_ASL_M = 6'd29,
    KIND_ASL_A = 6'd30,
    KIND_ROL_M = 6'd31,
    KIND_ROL_A = 6'd32,
    KIND_ROR_M = 6'd33,
    KIND_ROR_A = 6'd34,
    KIND_SEC   = 6'd35,
    KIND_CLC   = 6'd36,
    KIND_CLV   = 6'd37,
    KIND_SEI   = 6'd38,
    KIND_CLI   = 6'd39,
    KIND_SED   = 6'd40,
    KIND_CLD   = 6'd41,
    KIND_NOP   = 6'd42
  } kind_e;

  typedef enum logic [1:0] {
    SHIFT_LSR = 2'd0,
    SHIFT_ASL = 2'd1,
    SHIFT_ROL = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_e;

endpackage

`default_nettype wire

// ----- rtl/cpu_register_alu_execute_unit.sv -----
// Execute stage: register file, ALU and flags of an 8-bit processor core.
//
//  channel  dir  tdata (low bit up)                       tuser
//  s_axis   in   mem_data[7:0]                            kind[5:0]
//  m_axis   out  write_data, acc, x, y, status (8b each)  write_enable[0]
//
// One beat per cycle unless stalled; the result beat appears in the cycle
// after acceptance. The registers update in the same edge that accepts
// the beat, so each operation sees the state left by the one before.
// A single output register holds the result; input is taken whenever that
// register is empty or being drained in the same cycle.
// Reset clears A, X, Y and SP and sets status to interrupt disable only.
`default_nettype none

module cpu_register_alu_execute_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // mem_data[7:0]
  input  wire logic [5:0]  s_axis_tuser,   // kind[5:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // write_data, acc, x, y, status
  output logic [0:0]       m_axis_tuser    // write_enable
);

  localparam int unsigned W = creu_pkg::DATA_W;

  typedef struct packed {
    logic [W-1:0] res;
    logic         carry;
  } shift_res_t;

  function automatic shift_res_t do_shift(creu_pkg::shift_e op, logic [W-1:0] v,
                                          logic cin);
    shift_res_t r;
    case (op)
      creu_pkg::SHIFT_LSR: r = '{res: {1'b0, v[W-1:1]}, carry: v[0]};
      creu_pkg::SHIFT_ASL: r = '{res: {v[W-2:0], 1'b0}, carry: v[W-1]};
      creu_pkg::SHIFT_ROL: r = '{res: {v[W-2:0], cin}, carry: v[W-1]};
      creu_pkg::SHIFT_ROR: r = '{res: {cin, v[W-1:1]}, carry: v[0]};
      default:             r = '{res: v, carry: cin};
    endcase
    return r;
  endfunction

  logic [W-1:0] a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d;
  logic         out_valid_q;
  logic [39:0]  out_data_q;
  logic         out_wen_q;
  logic         in_fire;

  creu_pkg::kind_e kind;
  logic [W-1:0]    mem;
  logic [W-1:0]    wdata;
  logic            wen;

  // ALU shared pieces
  logic [W-1:0]    add_op;
  logic [W:0]      sum;
  logic [W-1:0]    cmp_reg;
  logic [W:0]      diff;
  creu_pkg::shift_e shift_op;
  logic [W-1:0]    shift_in;
  shift_res_t      shift_out;

  assign kind          = creu_pkg::kind_e'(s_axis_tuser);
  assign mem           = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // SBC is ADC of the inverted operand
  assign add_op = (kind == creu_pkg::KIND_SBC) ? ~mem : mem;
  assign sum    = {1'b0, a_q} + {1'b0, add_op} + {{W{1'b0}}, p_q[creu_pkg::FLAG_C]};

  always_comb begin
    case (kind)
      creu_pkg::KIND_CPX: cmp_reg = x_q;
      creu_pkg::KIND_CPY: cmp_reg = y_q;
      default:            cmp_reg = a_q;
    endcase
  end
  assign diff = {1'b0, cmp_reg} - {1'b0, mem};

  always_comb begin
    case (kind)
      creu_pkg::KIND_ASL_M, creu_pkg::KIND_ASL_A: shift_op = creu_pkg::SHIFT_ASL;
      creu_pkg::KIND_ROL_M, creu_pkg::KIND_ROL_A: shift_op = creu_pkg::SHIFT_ROL;
      creu_pkg::KIND_ROR_M, creu_pkg::KIND_ROR_A: shift_op = creu_pkg::SHIFT_ROR;
      default:                                    shift_op = creu_pkg::SHIFT_LSR;
    endcase
  end
  // memory forms have odd codes
  assign shift_in  = kind[0] ? mem : a_q;
  assign shift_out = do_shift(shift_op, shift_in, p_q[creu_pkg::FLAG_C]);

  always_comb begin
    logic [W-1:0] nz_val;
    logic         nz_upd;
    a_d    = a_q;
    x_d    = x_q;
    y_d    = y_q;
    sp_d   = sp_q;
    p_d    = p_q;
    wdata  = '0;
    wen    = 1'b0;
    nz_val = '0;
    nz_upd = 1'b0;
    case (kind)
      creu_pkg::KIND_LDA: begin a_d = mem; nz_val = mem; nz_upd = 1'b1; end
      creu_pkg::KIND_LDX: begin x_d = mem; nz_val = mem; nz_upd = 1'b1; end
      creu_pkg::KIND_LDY: begin y_d = mem; nz_val = mem; nz_upd = 1'b1; end
      creu_pkg::KIND_STA: begin wdata = a_q; wen = 1'b1; end
      creu_pkg::KIND_STX: begin wdata = x_q; wen = 1'b1; end
      creu_pkg::KIND_STY: begin wdata = y_q; wen = 1'b1; end
      creu_pkg::KIND_TAX: begin x_d = a_q; nz_val = a_q; nz_upd = 1'b1; end
      creu_pkg::KIND_TAY: begin y_d = a_q; nz_val = a_q; nz_upd = 1'b1; end
      creu_pkg::KIND_TXA: begin a_d = x_q; nz_val = x_q; nz_upd = 1'b1; end
      creu_pkg::KIND_TYA: begin a_d = y_q; nz_val = y_q; nz_upd = 1'b1; end
      creu_pkg::KIND_TXS: sp_d = x_q;
      creu_pkg::KIND_TSX: begin x_d = sp_q; nz_val = sp_q; nz_upd = 1'b1; end
      creu_pkg::KIND_ADC, creu_pkg::KIND_SBC: begin
        a_d                   = sum[W-1:0];
        p_d[creu_pkg::FLAG_C] = sum[W];
        p_d[creu_pkg::FLAG_V] = (a_q[W-1] ^ sum[W-1]) & (add_op[W-1] ^ sum[W-1]);
        nz_val                = sum[W-1:0];
        nz_upd                = 1'b1;
      end
      creu_pkg::KIND_AND: begin a_d = a_q & mem; nz_val = a_q & mem; nz_upd = 1'b1; end
      creu_pkg::KIND_ORA: begin a_d = a_q | mem; nz_val = a_q | mem; nz_upd = 1'b1; end
      creu_pkg::KIND_EOR: begin a_d = a_q ^ mem; nz_val = a_q ^ mem; nz_upd = 1'b1; end
      creu_pkg::KIND_INX: begin x_d = x_q + 8'd1; nz_val = x_q + 8'd1; nz_upd = 1'b1; end
      creu_pkg::KIND_INY: begin y_d = y_q + 8'd1; nz_val = y_q + 8'd1; nz_upd = 1'b1; end
      creu_pkg::KIND_DEX: begin x_d = x_q - 8'd1; nz_val = x_q - 8'd1; nz_upd = 1'b1; end
      creu_pkg::KIND_DEY: begin y_d = y_q - 8'd1; nz_val = y_q - 8'd1; nz_upd = 1'b1; end
      creu_pkg::KIND_INC: begin
        wdata = mem + 8'd1; wen = 1'b1; nz_val = mem + 8'd1; nz_upd = 1'b1;
      end
      creu_pkg::KIND_DEC: begin
        wdata = mem - 8'd1; wen = 1'b1; nz_val = mem - 8'd1; nz_upd = 1'b1;
      end
      creu_pkg::KIND_CMP, creu_pkg::KIND_CPX, creu_pkg::KIND_CPY: begin
        p_d[creu_pkg::FLAG_C] = !diff[W];   // no borrow: reg >= mem
        p_d[creu_pkg::FLAG_Z] = (cmp_reg == mem);
        p_d[creu_pkg::FLAG_N] = diff[W-1];
      end
      creu_pkg::KIND_BIT: begin
        p_d[creu_pkg::FLAG_Z] = ((a_q & mem) == '0);
        p_d[creu_pkg::FLAG_N] = mem[W-1];
        p_d[creu_pkg::FLAG_V] = mem[W-2];
      end
      creu_pkg::KIND_LSR_M, creu_pkg::KIND_ASL_M,
      creu_pkg::KIND_ROL_M, creu_pkg::KIND_ROR_M: begin
        wdata                 = shift_out.res;
        wen                   = 1'b1;
        p_d[creu_pkg::FLAG_C] = shift_out.carry;
        nz_val                = shift_out.res;
        nz_upd                = 1'b1;
      end
      creu_pkg::KIND_LSR_A, creu_pkg::KIND_ASL_A,
      creu_pkg::KIND_ROL_A, creu_pkg::KIND_ROR_A: begin
        a_d                   = shift_out.res;
        p_d[creu_pkg::FLAG_C] = shift_out.carry;
        nz_val                = shift_out.res;
        nz_upd                = 1'b1;
      end
      creu_pkg::KIND_SEC: p_d[creu_pkg::FLAG_C] = 1'b1;
      creu_pkg::KIND_CLC: p_d[creu_pkg::FLAG_C] = 1'b0;
      creu_pkg::KIND_CLV: p_d[creu_pkg::FLAG_V] = 1'b0;
      creu_pkg::KIND_SEI: p_d[creu_pkg::FLAG_I] = 1'b1;
      creu_pkg::KIND_CLI: p_d[creu_pkg::FLAG_I] = 1'b0;
      creu_pkg::KIND_SED: p_d[creu_pkg::FLAG_D] = 1'b1;
      creu_pkg::KIND_CLD: p_d[creu_pkg::FLAG_D] = 1'b0;
      default: ;  // NOP and unused codes
    endcase
    if (nz_upd) begin
      p_d[creu_pkg::FLAG_N] = nz_val[W-1];
      p_d[creu_pkg::FLAG_Z] = (nz_val == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      sp_q        <= '0;
      p_q         <= creu_pkg::STATUS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        a_q  <= a_d;
        x_q  <= x_d;
        y_q  <= y_d;
        sp_q <= sp_d;
        p_q  <= p_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {p_d, y_d, x_d, a_d, wdata};
      out_wen_q  <= wen;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_wen_q;

endmodule

`default_nettype wire

// ----- rtl/creu_checker.sv -----
// Port-level checks for the execute unit, bound to the top level.
`default_nettype none

module creu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic [5:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // every accepted beat shows up at the output on the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // input is held off only while a result is stuck at the output
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready) |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  a_status_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[39:32] & creu_pkg::STATUS_UNUSED_MASK) == 8'h00))
    else $error("status bits 5:4 set");

  a_no_write_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("write data nonzero without write enable");

  // keep the input payload ports referenced
  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

endmodule

bind cpu_register_alu_execute_unit creu_checker u_creu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the register/ALU execute unit: directed ops, random ops, stalls.
module tb_top;
  import creu_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 6'd43;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 6'd63;

  typedef struct packed {
    logic [7:0] write_data;
    logic       write_enable;
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] status;
  } exec_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // mem_data[7:0]
  logic [5:0]  s_axis_tuser  = '0;   // kind[5:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // write_data, acc, x, y, status
  logic [0:0]  m_axis_tuser;         // write_enable

  cpu_register_alu_execute_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the architectural registers
  logic [7:0] acc_r, x_r, y_r, sp_r, p_r;

  exec_result_t pending_results[$];
  int ops_sent       = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int fail_count     = 0;
  int rx_hold_left   = 0;
  int rx_stall_left  = 0;
  int idle_cycles    = 0;
  bit quiet_mode     = 1'b0;

  function automatic void set_nz(input logic [7:0] v);
    p_r[FLAG_N] = v[7];
    p_r[FLAG_Z] = (v == 8'h00);
  endfunction

  function automatic void add_carry(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, acc_r} + {1'b0, m} + {8'h00, p_r[FLAG_C]};
    p_r[FLAG_C] = sum[8];
    p_r[FLAG_V] = ((acc_r ^ sum[7:0]) & (m ^ sum[7:0]) & 8'h80) != 8'h00;
    acc_r = sum[7:0];
    set_nz(acc_r);
  endfunction

  function automatic void compare_flags(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    p_r[FLAG_C] = (r >= m);
    p_r[FLAG_Z] = (r == m);
    p_r[FLAG_N] = d[7];
  endfunction

  function automatic logic [7:0] shift_byte(input shift_e op, input logic [7:0] v);
    logic       cin;
    logic [7:0] r;
    cin = p_r[FLAG_C];
    case (op)
      SHIFT_LSR: begin p_r[FLAG_C] = v[0]; r = {1'b0, v[7:1]}; end
      SHIFT_ASL: begin p_r[FLAG_C] = v[7]; r = {v[6:0], 1'b0}; end
      SHIFT_ROL: begin p_r[FLAG_C] = v[7]; r = {v[6:0], cin}; end
      default:   begin p_r[FLAG_C] = v[0]; r = {cin, v[7:1]}; end
    endcase
    set_nz(r);
    return r;
  endfunction

  // Applies one operation to the shadow registers and returns the expected beat
  function automatic exec_result_t predict_exec(input logic [5:0] kind, input logic [7:0] m);
    exec_result_t r;
    r = '0;
    case (kind)
      KIND_LDA:   begin acc_r = m; set_nz(m); end
      KIND_LDX:   begin x_r = m; set_nz(m); end
      KIND_LDY:   begin y_r = m; set_nz(m); end
      KIND_STA:   begin r.write_data = acc_r; r.write_enable = 1'b1; end
      KIND_STX:   begin r.write_data = x_r; r.write_enable = 1'b1; end
      KIND_STY:   begin r.write_data = y_r; r.write_enable = 1'b1; end
      KIND_TAX:   begin x_r = acc_r; set_nz(x_r); end
      KIND_TAY:   begin y_r = acc_r; set_nz(y_r); end
      KIND_TXA:   begin acc_r = x_r; set_nz(acc_r); end
      KIND_TYA:   begin acc_r = y_r; set_nz(acc_r); end
      KIND_TXS:   sp_r = x_r;
      KIND_TSX:   begin x_r = sp_r; set_nz(x_r); end
      KIND_ADC:   add_carry(m);
      KIND_SBC:   add_carry(~m);
      KIND_AND:   begin acc_r = acc_r & m; set_nz(acc_r); end
      KIND_ORA:   begin acc_r = acc_r | m; set_nz(acc_r); end
      KIND_EOR:   begin acc_r = acc_r ^ m; set_nz(acc_r); end
      KIND_INX:   begin x_r = x_r + 8'd1; set_nz(x_r); end
      KIND_INY:   begin y_r = y_r + 8'd1; set_nz(y_r); end
      KIND_DEX:   begin x_r = x_r - 8'd1; set_nz(x_r); end
      KIND_DEY:   begin y_r = y_r - 8'd1; set_nz(y_r); end
      KIND_INC:   begin r.write_data = m + 8'd1; r.write_enable = 1'b1; set_nz(r.write_data); end
      KIND_DEC:   begin r.write_data = m - 8'd1; r.write_enable = 1'b1; set_nz(r.write_data); end
      KIND_CMP:   compare_flags(acc_r, m);
      KIND_CPX:   compare_flags(x_r, m);
      KIND_CPY:   compare_flags(y_r, m);
      KIND_BIT: begin
        p_r[FLAG_Z] = ((acc_r & m) == 8'h00);
        p_r[FLAG_N] = m[7];
        p_r[FLAG_V] = m[6];
      end
      KIND_LSR_M: begin r.write_data = shift_byte(SHIFT_LSR, m); r.write_enable = 1'b1; end
      KIND_ASL_M: begin r.write_data = shift_byte(SHIFT_ASL, m); r.write_enable = 1'b1; end
      KIND_ROL_M: begin r.write_data = shift_byte(SHIFT_ROL, m); r.write_enable = 1'b1; end
      KIND_ROR_M: begin r.write_data = shift_byte(SHIFT_ROR, m); r.write_enable = 1'b1; end
      KIND_LSR_A: acc_r = shift_byte(SHIFT_LSR, acc_r);
      KIND_ASL_A: acc_r = shift_byte(SHIFT_ASL, acc_r);
      KIND_ROL_A: acc_r = shift_byte(SHIFT_ROL, acc_r);
      KIND_ROR_A: acc_r = shift_byte(SHIFT_ROR, acc_r);
      KIND_SEC:   p_r[FLAG_C] = 1'b1;
      KIND_CLC:   p_r[FLAG_C] = 1'b0;
      KIND_CLV:   p_r[FLAG_V] = 1'b0;
      KIND_SEI:   p_r[FLAG_I] = 1'b1;
      KIND_CLI:   p_r[FLAG_I] = 1'b0;
      KIND_SED:   p_r[FLAG_D] = 1'b1;
      KIND_CLD:   p_r[FLAG_D] = 1'b0;
      default:    ; // NOP and unused codes
    endcase
    r.acc    = acc_r;
    r.x      = x_r;
    r.y      = y_r;
    r.status = p_r;
    return r;
  endfunction

  // Predict on each input beat, check each output beat against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    exec_result_t got, want;
    if (!rst_ni) begin
      acc_r = '0; x_r = '0; y_r = '0; sp_r = '0;
      p_r   = STATUS_RESET;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.write_data   = m_axis_tdata[7:0];
        got.write_enable = m_axis_tuser[0];
        got.acc          = m_axis_tdata[15:8];
        got.x            = m_axis_tdata[23:16];
        got.y            = m_axis_tdata[31:24];
        got.status       = m_axis_tdata[39:32];
        results_seen++;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("ERROR: unexpected result beat at %0t", $time);
        end else begin
          want = pending_results.pop_front();
          if (got.write_data !== want.write_data || got.write_enable !== want.write_enable ||
              got.acc !== want.acc || got.x !== want.x || got.y !== want.y ||
              got.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("MISMATCH at %0t: exp wd=%h we=%b a=%h x=%h y=%h p=%h",
                       $time, want.write_data, want.write_enable, want.acc, want.x, want.y,
                       want.status);
              $display("                 got wd=%h we=%b a=%h x=%h y=%h p=%h",
                       got.write_data, got.write_enable, got.acc, got.x, got.y,
                       got.status);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(predict_exec(s_axis_tuser, s_axis_tdata));
    end
  end

  // Result side: random stall bursts, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left = $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [5:0] kind, input logic [7:0] mem);
    int gap;
    gap = 0;
    if (!quiet_mode && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mem;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ops_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_load_store_transfer();
    send_op(KIND_STA, 8'hff);   // reset state write-back
    send_op(KIND_LDA, 8'h00);
    send_op(KIND_LDA, 8'h80);
    send_op(KIND_LDX, 8'hff);
    send_op(KIND_LDY, 8'h7f);
    send_op(KIND_STA, 8'h00);
    send_op(KIND_STX, 8'h55);
    send_op(KIND_STY, 8'haa);
    send_op(KIND_TAX, 8'hff);
    send_op(KIND_TAY, 8'hff);
    send_op(KIND_LDX, 8'h00);
    send_op(KIND_TXA, 8'hff);
    send_op(KIND_TYA, 8'h00);
    send_op(KIND_TXS, 8'h12);
    send_op(KIND_LDX, 8'h34);
    send_op(KIND_TSX, 8'h00);
  endtask

  task automatic test_inc_dec_compare();
    send_op(KIND_LDX, 8'hff);
    send_op(KIND_INX, 8'h00);   // wrap to zero
    send_op(KIND_DEX, 8'h00);   // wrap to 0xff
    send_op(KIND_INY, 8'hff);
    send_op(KIND_DEY, 8'hff);
    send_op(KIND_INC, 8'hff);
    send_op(KIND_DEC, 8'h00);
    send_op(KIND_INC, 8'h7f);
    send_op(KIND_CMP, 8'h80);
    send_op(KIND_CPX, 8'h00);
    send_op(KIND_CPY, 8'hff);
    send_op(KIND_LDA, 8'h40);
    send_op(KIND_CMP, 8'h40);
    send_op(KIND_BIT, 8'hc0);
    send_op(KIND_BIT, 8'h3f);
  endtask

  task automatic test_adc_sbc_logic();
    send_op(KIND_CLC, 8'h00);
    send_op(KIND_LDA, 8'h7f);
    send_op(KIND_ADC, 8'h01);   // signed overflow
    send_op(KIND_ADC, 8'hff);   // unsigned carry out
    send_op(KIND_ADC, 8'h80);
    send_op(KIND_SEC, 8'h00);
    send_op(KIND_SBC, 8'h01);
    send_op(KIND_LDA, 8'h80);
    send_op(KIND_SBC, 8'h01);   // signed overflow on subtract
    send_op(KIND_CLC, 8'h00);
    send_op(KIND_SBC, 8'h00);   // borrow in
    send_op(KIND_LDA, 8'h00);
    send_op(KIND_SBC, 8'hff);   // borrow out
    send_op(KIND_AND, 8'hf0);
    send_op(KIND_ORA, 8'h8f);
    send_op(KIND_EOR, 8'hff);
    send_op(KIND_AND, 8'h00);
  endtask

  task automatic test_shift_rotate();
    send_op(KIND_LDA, 8'h81);
    send_op(KIND_SEC, 8'h00);
    send_op(KIND_ROR_A, 8'h00);
    send_op(KIND_ROL_A, 8'hff);
    send_op(KIND_LSR_A, 8'h00);
    send_op(KIND_ASL_A, 8'h00);
    send_op(KIND_LSR_M, 8'h01);
    send_op(KIND_ASL_M, 8'h80);
    send_op(KIND_SEC, 8'h00);
    send_op(KIND_ROL_M, 8'hff);
    send_op(KIND_ROR_M, 8'h01);
  endtask

  task automatic test_flag_ops_unused();
    send_op(KIND_SEC, 8'hff);
    send_op(KIND_CLC, 8'hff);
    send_op(KIND_LDA, 8'h00);
    send_op(KIND_BIT, 8'h40);
    send_op(KIND_CLV, 8'h00);
    send_op(KIND_CLI, 8'h00);
    send_op(KIND_SEI, 8'h00);
    send_op(KIND_SED, 8'h00);
    send_op(KIND_ADC, 8'h09);   // decimal flag set, binary result expected
    send_op(KIND_CLD, 8'h00);
    send_op(KIND_NOP, 8'hff);
    send_op(KIND_UNUSED_LO, 8'hff);
    send_op(KIND_UNUSED_HI, 8'h00);
  endtask

  task automatic test_random_ops(input int count);
    logic [5:0] kind;
    logic [7:0] mem;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 93) kind = 6'($urandom_range(KIND_LDA, KIND_NOP));
      else kind = 6'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      case ($urandom_range(0, 9))
        0:       mem = 8'h00;
        1:       mem = 8'hff;
        2:       mem = 8'h7f;
        3:       mem = 8'h80;
        default: mem = 8'($urandom_range(0, 255));
      endcase
      send_op(kind, mem);
    end
  endtask

  // Result side holds off while the input keeps offering, so the unit stalls its input
  task automatic test_output_hold();
    wait_drained();
    rx_hold_left = HOLD_CYCLES;
    test_random_ops(20);
    wait_drained();   // sender pauses until every result is back
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_store_transfer();
    test_inc_dec_compare();
    test_adc_sbc_logic();
    test_shift_rotate();
    test_flag_ops_unused();
    test_random_ops(700);
    test_output_hold();
    quiet_mode = 1'b1;
    test_random_ops(700);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d results never arrived", pending_results.size());
    end
    $display("Summary: %0d ops (all kinds, unused codes, flag edges) and %0d results checked",
             ops_sent, results_seen);
    $display("Summary: random stalls on both sides, one long output hold; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/creu_pkg.sv
rtl/cpu_register_alu_execute_unit.sv
rtl/creu_checker.sv
tb/sv/tb_top.sv
